// File: rtl/token_bucket_rate_limiter_core_assert.svh
// Assertion macros used by the token bucket rate limiter core.
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TBRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define TBRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tbrl_pkg.sv
// Shared constants and codes for the token bucket rate limiter.
`timescale 1ns / 1ps

package tbrl_pkg;

  // Port field widths.
  localparam int NOW_W      = 48;
  localparam int COUNT_W    = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int WAIT_W     = 48;
  localparam int INTERVAL_W = 40;
  localparam int CAP_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = INTERVAL_W;

  // Datapath formats.
  localparam int TIME_BITS     = 48;
  localparam int FRACTION_BITS = 16;
  localparam int INTERVAL_FRAC = 8;
  localparam int SCALE_SHIFT   = FRACTION_BITS + INTERVAL_FRAC;
  localparam int STORE_W       = CAP_W + FRACTION_BITS;
  localparam int QUO_W         = STORE_W + 1;
  localparam int EXTRA_W       = INTERVAL_W + STORE_W - SCALE_SHIFT;
  localparam int ADV_W         = ((EXTRA_W > TIME_BITS) ? EXTRA_W : TIME_BITS) + 1;
  localparam int MS_TO_US      = 1000;
  localparam int TMO_W         = TIMEOUT_W + 10;

  // Iteration counts of the serial divider and multiplier.
  localparam int DIV_STEPS = TIME_BITS + SCALE_SHIFT;
  localparam int MUL_STEPS = STORE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [TIME_BITS-1:0]  TIME_MAX       = '1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(256000);
  localparam logic [CAP_W-1:0]      CAPACITY_RESET = CAP_W'(1);

  // Request opcodes.
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_TRY     = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(1);

endpackage

// File: rtl/token_bucket_rate_limiter_core.sv
// Token bucket rate limiter with a bit-serial refill divider and overdraft multiplier.
//
//   channel  direction  handshake             beat contents
//   in       input      in_valid / in_stall   opcode, now_time, permit_count, timeout_ms
//   out      output     out_valid / out_stall granted, delay_us
//   cfg      input      cfg_valid / cfg_ready register index, write data
//
// A refusal goes from the timeout check straight to the result. A grant runs the check, a
// refill if time has passed (a bit-serial divide if the interval is nonzero), the spend, an
// overdraft multiply if the interval is nonzero, the advance and the result. A finished
// result waits in the output register while the next request runs; a second result holds
// the core until out_stall drops. Synchronous reset fills the bucket at capacity 1, and
// configuration writes are taken only while no request is in progress.
`timescale 1ns / 1ps

module token_bucket_rate_limiter_core
  import tbrl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [NOW_W-1:0]      in_now_time,
  input  logic [COUNT_W-1:0]    in_permit_count,
  input  logic [TIMEOUT_W-1:0]  in_timeout_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_granted,
  output logic [WAIT_W-1:0]     out_delay_us,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_REFILL  = 3'd3;
  localparam logic [2:0] ST_SPEND   = 3'd4;
  localparam logic [2:0] ST_MUL     = 3'd5;
  localparam logic [2:0] ST_ADVANCE = 3'd6;
  localparam logic [2:0] ST_RESULT  = 3'd7;

  // Control and architectural state.
  logic [2:0]            state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [INTERVAL_W-1:0] ival_r, ival_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [STORE_W-1:0]    stored_r, stored_nxt;
  logic [TIME_BITS-1:0]  nft_r, nft_nxt;

  // Request and datapath registers.
  logic                  op_r, op_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [COUNT_W-1:0]    want_r, want_nxt;
  logic [TMO_W-1:0]      tmo_r, tmo_nxt;
  logic [TIME_BITS-1:0]  num_r, num_nxt;
  logic [INTERVAL_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]      q_r, q_nxt;
  logic                  qovf_r, qovf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [INTERVAL_W-1:0] acc_r, acc_nxt;
  logic [STORE_W-1:0]    mpl_r, mpl_nxt;
  logic                  res_grant_r, res_grant_nxt;
  logic [WAIT_W-1:0]     res_wait_r, res_wait_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [WAIT_W-1:0]     out_wait_r, out_wait_nxt;

  // Combinational helpers.
  logic [STORE_W-1:0]    cap_fixed;
  logic [STORE_W-1:0]    want_fixed;
  logic [TIME_BITS:0]    lim;
  logic                  refuse;
  logic [INTERVAL_W:0]   trial;
  logic                  trial_ge;
  logic [INTERVAL_W:0]   trial_diff;
  logic [STORE_W-1:0]    add;
  logic [STORE_W:0]      refill_sum;
  logic [STORE_W-1:0]    spend;
  logic [STORE_W-1:0]    fresh;
  logic [INTERVAL_W:0]   mul_sum;
  logic [EXTRA_W-1:0]    extra;
  logic [ADV_W-1:0]      adv_sum;
  logic                  in_fire;
  logic                  out_fire;

  assign cap_fixed  = {cap_r, FRACTION_BITS'(0)};
  assign want_fixed = {want_r, FRACTION_BITS'(0)};
  assign in_fire    = in_valid && !in_stall;
  assign out_fire   = out_valid_r && !out_stall;

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_granted   = out_granted_r;
  assign out_delay_us  = out_wait_r;

  // Deadline of a try-acquire; the top bit flags an overflow of the time width.
  assign lim    = {1'b0, now_r} + (TIME_BITS + 1)'(tmo_r);
  assign refuse = (op_r == OP_TRY) && !lim[TIME_BITS] && ({1'b0, nft_r} > lim);

  // One restoring division step: bring down the next elapsed-time bit.
  assign trial      = {rem_r, num_r[TIME_BITS-1]};
  assign trial_ge   = trial >= {1'b0, ival_r};
  assign trial_diff = trial - {1'b0, ival_r};

  // The quotient saturates at capacity; a zero interval fills the bucket at once.
  assign add = ((ival_r == '0) || qovf_r || (q_r > QUO_W'(cap_fixed))) ?
               cap_fixed : q_r[STORE_W-1:0];
  assign refill_sum = {1'b0, stored_r} + {1'b0, add};

  assign spend = (want_fixed < stored_r) ? want_fixed : stored_r;
  assign fresh = want_fixed - spend;

  // Shift-add multiply of the overdraft by the interval, multiplier LSB first.
  assign mul_sum = {1'b0, acc_r} + (mpl_r[0] ? {1'b0, ival_r} : (INTERVAL_W + 1)'(0));
  assign extra   = {acc_r, mpl_r[STORE_W-1:SCALE_SHIFT]};
  assign adv_sum = ADV_W'(nft_r) + ADV_W'(extra);

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    ival_nxt        = ival_r;
    cap_nxt         = cap_r;
    stored_nxt      = stored_r;
    nft_nxt         = nft_r;
    op_nxt          = op_r;
    now_nxt         = now_r;
    want_nxt        = want_r;
    tmo_nxt         = tmo_r;
    num_nxt         = num_r;
    rem_nxt         = rem_r;
    q_nxt           = q_r;
    qovf_nxt        = qovf_r;
    cnt_nxt         = cnt_r;
    acc_nxt         = acc_r;
    mpl_nxt         = mpl_r;
    res_grant_nxt   = res_grant_r;
    res_wait_nxt    = res_wait_r;
    out_granted_nxt = out_granted_r;
    out_wait_nxt    = out_wait_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INTERVAL: ival_nxt = cfg_wdata[INTERVAL_W-1:0];
        REG_CAPACITY: begin
          cap_nxt    = cfg_wdata[CAP_W-1:0];
          stored_nxt = {cfg_wdata[CAP_W-1:0], FRACTION_BITS'(0)};
        end
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_opcode;
          now_nxt   = TIME_BITS'(in_now_time);
          want_nxt  = in_permit_count;
          tmo_nxt   = TMO_W'(in_timeout_ms) * TMO_W'(MS_TO_US);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (refuse) begin
          res_grant_nxt = 1'b0;
          res_wait_nxt  = '0;
          state_nxt     = ST_RESULT;
        end else begin
          res_grant_nxt = 1'b1;
          if (now_r > nft_r) begin
            num_nxt  = now_r - nft_r;
            rem_nxt  = '0;
            q_nxt    = '0;
            qovf_nxt = 1'b0;
            cnt_nxt  = CNT_W'(DIV_STEPS);
            state_nxt = (ival_r == '0) ? ST_REFILL : ST_DIV;
          end else begin
            state_nxt = ST_SPEND;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? trial_diff[INTERVAL_W-1:0] : trial[INTERVAL_W-1:0];
        num_nxt  = {num_r[TIME_BITS-2:0], 1'b0};
        q_nxt    = {q_r[QUO_W-2:0], trial_ge};
        qovf_nxt = qovf_r | q_r[QUO_W-1];
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_REFILL;
        end
      end
      ST_REFILL: begin
        stored_nxt = (refill_sum > {1'b0, cap_fixed}) ? cap_fixed : refill_sum[STORE_W-1:0];
        nft_nxt    = now_r;
        state_nxt  = ST_SPEND;
      end
      ST_SPEND: begin
        res_wait_nxt = WAIT_W'(nft_r - now_r);
        stored_nxt   = stored_r - spend;
        acc_nxt      = '0;
        cnt_nxt      = CNT_W'(MUL_STEPS);
        if ((fresh == '0) || (ival_r == '0)) begin
          mpl_nxt   = '0;
          state_nxt = ST_ADVANCE;
        end else begin
          mpl_nxt   = fresh;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = mul_sum[INTERVAL_W:1];
        mpl_nxt = {mul_sum[0], mpl_r[STORE_W-1:1]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        nft_nxt   = (adv_sum > ADV_W'(TIME_MAX)) ? TIME_MAX : adv_sum[TIME_BITS-1:0];
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_grant_r;
          out_wait_nxt    = res_wait_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ival_r      <= INTERVAL_RESET;
      cap_r       <= CAPACITY_RESET;
      stored_r    <= {CAPACITY_RESET, FRACTION_BITS'(0)};
      nft_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ival_r      <= ival_nxt;
      cap_r       <= cap_nxt;
      stored_r    <= stored_nxt;
      nft_r       <= nft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    now_r         <= now_nxt;
    want_r        <= want_nxt;
    tmo_r         <= tmo_nxt;
    num_r         <= num_nxt;
    rem_r         <= rem_nxt;
    q_r           <= q_nxt;
    qovf_r        <= qovf_nxt;
    cnt_r         <= cnt_nxt;
    acc_r         <= acc_nxt;
    mpl_r         <= mpl_nxt;
    res_grant_r   <= res_grant_nxt;
    res_wait_r    <= res_wait_nxt;
    out_granted_r <= out_granted_nxt;
    out_wait_r    <= out_wait_nxt;
  end

`include "token_bucket_rate_limiter_core_assert.svh"

  // The bucket never holds more than its capacity.
  `TBRL_ASSERT_NOW(a_stored_capped, 1'b1, stored_r <= cap_fixed, "stored permits above capacity")
  // A refused request reports no wait.
  `TBRL_ASSERT_NOW(a_refused_no_wait, out_valid_r && !out_granted_r, out_wait_r == '0, "refusal with wait")
  // An accepted beat always starts with the timeout check.
  `TBRL_ASSERT_NEXT(a_accept_check, in_fire, state_r == ST_CHECK, "accepted beat skipped check")
  // The multiplier only runs with a nonzero interval.
  `TBRL_ASSERT_NOW(a_mul_interval, state_r == ST_MUL, ival_r != '0, "multiply with zero interval")

endmodule
